// ----- rtl/pshg_pkg.sv -----
// Shared types and constants for the PPPoE session header gateway.
// No dependencies; imported by every module of the block.
package pshg_pkg;

	// Ethernet types
	localparam logic [15:0] ET_SESSION   = 16'h8864;
	localparam logic [15:0] ET_DISCOVERY = 16'h8863;
	localparam logic [15:0] ET_ARP       = 16'h0806;
	localparam logic [15:0] ET_IPV4      = 16'h0800;
	localparam logic [15:0] ET_IPV6      = 16'h86DD;

	// PPP protocol words
	localparam logic [15:0] PPP_IPV4 = 16'h0021;
	localparam logic [15:0] PPP_IPV6 = 16'h0057;
	localparam logic [15:0] PPP_LCP  = 16'hC021;
	localparam logic [15:0] PPP_PAP  = 16'hC023;
	localparam logic [15:0] PPP_IPCP = 16'h8021;

	localparam logic [15:0] ARP_REQUEST = 16'h0001;

	localparam logic [10:0] LEN_MAX = 11'h7FF;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LAN_PORT_MAC   = 3'd0,
		REG_LAN_SIDE_MAC   = 3'd1,
		REG_WAN_SOURCE_MAC = 3'd2,
		REG_WAN_PEER_MAC   = 3'd3,
		REG_GATEWAY_IP     = 3'd4,
		REG_SESSION_NUMBER = 3'd5,
		REG_DP_ENABLE      = 3'd6
	} reg_idx_t;

	// Verdict / class codes
	typedef enum logic [2:0] {
		CLS_DROP  = 3'd0,
		CLS_ENCAP = 3'd1,
		CLS_DECAP = 3'd2,
		CLS_CTRL  = 3'd3,
		CLS_ARP   = 3'd4
	} cls_t;

	typedef struct packed {
		logic        from_wan;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] eth_type;
		logic [15:0] ppp_proto_in;
		logic [15:0] arp_opcode;
		logic [47:0] arp_sender_mac;
		logic [31:0] arp_sender_ip;
		logic [31:0] arp_target_ip;
		logic [10:0] frame_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [47:0] out_dst_mac;
		logic [47:0] out_src_mac;
		logic [15:0] out_ether_type;
		logic [15:0] pppoe_length;
		logic [15:0] out_session;
		logic [15:0] ppp_proto_out;
		logic [31:0] reply_sender_ip;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_target_ip;
		logic [10:0] out_length;
	} out_item_t;

	typedef struct packed {
		logic [47:0] lan_port_mac;
		logic [47:0] lan_side_mac;
		logic [47:0] wan_source_mac;
		logic [47:0] wan_peer_mac;
		logic [31:0] gateway_ip;
		logic [15:0] session_number;
		logic        data_plane_enable;
	} cfg_t;

	// Classified header held in the queue between front and back
	typedef struct packed {
		cls_t        cls;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] eth_type;
		logic [15:0] ppp_proto_in;
		logic [47:0] arp_sender_mac;
		logic [31:0] arp_sender_ip;
		logic [10:0] frame_length;
	} q_entry_t;

endpackage

// ----- rtl/pshg_front.sv -----
// Front end: classifies an arriving header into its verdict class.
// Depends on pshg_pkg.
module pshg_front (
	input  pshg_pkg::in_item_t in_item,
	input  pshg_pkg::cfg_t     cfg,
	output pshg_pkg::q_entry_t entry
);
	import pshg_pkg::*;

	logic wan_ctrl;
	logic arp_hit;
	cls_t cls;

	// control traffic: discovery, or LCP/PAP/IPCP in a session
	assign wan_ctrl = (in_item.eth_type == ET_DISCOVERY) ||
		((in_item.eth_type == ET_SESSION) &&
		((in_item.ppp_proto_in == PPP_LCP) || (in_item.ppp_proto_in == PPP_PAP) ||
		(in_item.ppp_proto_in == PPP_IPCP)));

	assign arp_hit = (in_item.arp_opcode == ARP_REQUEST) &&
		(in_item.arp_target_ip == cfg.gateway_ip);

	// classification
	always_comb begin
		cls = CLS_DROP;
		if (in_item.from_wan) begin
			if (wan_ctrl) begin
				cls = CLS_CTRL;
			end else if (in_item.eth_type == ET_SESSION) begin
				cls = CLS_DECAP;
			end
		end else if (cfg.data_plane_enable) begin
			if (in_item.eth_type == ET_ARP) begin
				if (arp_hit) begin
					cls = CLS_ARP;
				end
			end else if ((in_item.eth_type != ET_DISCOVERY) &&
				(in_item.eth_type != ET_SESSION)) begin
				cls = CLS_ENCAP;
			end
		end
	end

	assign entry.cls            = cls;
	assign entry.dst_mac        = in_item.dst_mac;
	assign entry.src_mac        = in_item.src_mac;
	assign entry.eth_type       = in_item.eth_type;
	assign entry.ppp_proto_in   = in_item.ppp_proto_in;
	assign entry.arp_sender_mac = in_item.arp_sender_mac;
	assign entry.arp_sender_ip  = in_item.arp_sender_ip;
	assign entry.frame_length   = in_item.frame_length;

endmodule

// ----- rtl/pshg_queue.sv -----
// Two-entry queue decoupling the classifier from the rewrite stage.
// Depends on pshg_pkg.
module pshg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  pshg_pkg::q_entry_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output pshg_pkg::q_entry_t pop_data
);
	import pshg_pkg::*;

	q_entry_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/pshg_back.sv -----
// Back end: rewrites the header for its class, learns the client MAC on
// answered ARP requests and holds the result in an output register.
// Depends on pshg_pkg.
module pshg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pshg_pkg::cfg_t      cfg,
	input  logic                entry_valid,
	output logic                entry_ready,
	input  pshg_pkg::q_entry_t  entry,
	output logic                out_valid,
	input  logic                out_ready,
	output pshg_pkg::out_item_t out_item
);
	import pshg_pkg::*;

	logic [47:0] client_mac_q;
	logic        client_known_q;
	logic        out_valid_q;
	out_item_t   out_item_q;
	out_item_t   res;
	logic        take;
	logic [11:0] len_plus8;

	assign entry_ready = !out_valid_q || out_ready;
	assign take        = entry_valid && entry_ready;
	assign len_plus8   = {1'b0, entry.frame_length} + 12'd8;
	assign out_valid   = out_valid_q;
	assign out_item    = out_item_q;

	// result for the queue head
	always_comb begin
		res         = '0;
		res.verdict = entry.cls;
		case (entry.cls)
			CLS_CTRL: begin
				res.out_dst_mac    = entry.dst_mac;
				res.out_src_mac    = entry.src_mac;
				res.out_ether_type = entry.eth_type;
				res.out_length     = entry.frame_length;
			end
			CLS_DECAP: begin
				res.out_dst_mac = client_mac_q;
				res.out_src_mac = cfg.lan_side_mac;
				if (entry.ppp_proto_in == PPP_IPV4) begin
					res.out_ether_type = ET_IPV4;
				end else if (entry.ppp_proto_in == PPP_IPV6) begin
					res.out_ether_type = ET_IPV6;
				end else begin
					res.out_ether_type = entry.ppp_proto_in;
				end
				res.out_length = (entry.frame_length >= 11'd8) ?
					entry.frame_length - 11'd8 : 11'd0;
			end
			CLS_ARP: begin
				res.out_dst_mac      = entry.src_mac;
				res.out_src_mac      = cfg.lan_port_mac;
				res.out_ether_type   = ET_ARP;
				res.reply_sender_ip  = cfg.gateway_ip;
				res.reply_target_mac = entry.arp_sender_mac;
				res.reply_target_ip  = entry.arp_sender_ip;
				res.out_length       = entry.frame_length;
			end
			CLS_ENCAP: begin
				res.out_dst_mac    = cfg.wan_peer_mac;
				res.out_src_mac    = cfg.wan_source_mac;
				res.out_ether_type = ET_SESSION;
				res.pppoe_length   = (entry.frame_length >= 11'd12) ?
					{5'd0, entry.frame_length - 11'd12} : 16'd0;
				res.out_session    = cfg.session_number;
				if (entry.eth_type == ET_IPV4) begin
					res.ppp_proto_out = PPP_IPV4;
				end else if (entry.eth_type == ET_IPV6) begin
					res.ppp_proto_out = PPP_IPV6;
				end else begin
					res.ppp_proto_out = entry.eth_type;
				end
				res.out_length = len_plus8[11] ? LEN_MAX : len_plus8[10:0];
			end
			default: begin
				res.verdict = CLS_DROP;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (take) begin
			out_item_q <= res;
		end
	end

	// valid flag and learned client
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			client_mac_q   <= 48'd0;
			client_known_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take && (entry.cls == CLS_ARP)) begin
				client_mac_q   <= entry.src_mac;
				client_known_q <= 1'b1;
			end else begin
				client_known_q <= client_known_q;
			end
		end
	end

endmodule

// ----- rtl/pppoe_session_header_gateway.sv -----
// PPPoE session header gateway, one result per parsed frame header. Headers
// are accepted at one per clock while the queue has room; a header is held in
// the queue, then its result in the rewrite stage's output register. The
// classifier and the rewrite stage sit on either side of a two-entry queue, so
// the input keeps taking headers while a result waits at the output, until the
// queue is full. The client MAC learned from an answered ARP request applies
// to every later decapsulated header. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce this.
// Depends on pshg_pkg, pshg_front, pshg_queue and pshg_back.
module pppoe_session_header_gateway (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  pshg_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output pshg_pkg::out_item_t out_item
);
	import pshg_pkg::*;

	cfg_t     cfg_q;
	q_entry_t front_entry;
	q_entry_t head_entry;
	logic     head_valid;
	logic     head_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LAN_PORT_MAC:   cfg_q.lan_port_mac      <= cfg_wdata;
				REG_LAN_SIDE_MAC:   cfg_q.lan_side_mac      <= cfg_wdata;
				REG_WAN_SOURCE_MAC: cfg_q.wan_source_mac    <= cfg_wdata;
				REG_WAN_PEER_MAC:   cfg_q.wan_peer_mac      <= cfg_wdata;
				REG_GATEWAY_IP:     cfg_q.gateway_ip        <= cfg_wdata[31:0];
				REG_SESSION_NUMBER: cfg_q.session_number    <= cfg_wdata[15:0];
				REG_DP_ENABLE:      cfg_q.data_plane_enable <= cfg_wdata[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pshg_front u_front (
		.in_item (in_item),
		.cfg     (cfg_q),
		.entry   (front_entry)
	);

	pshg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_entry),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head_entry)
	);

	pshg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.entry_valid (head_valid),
		.entry_ready (head_ready),
		.entry       (head_entry),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule
